[src/llrb_pkg.sv]
// shared types, constants and codes for the last-n-lines ring buffer
`timescale 1ns / 1ps
`default_nettype none
package llrb_pkg;

    localparam int MAX_LINES_DEF  = 128;
    localparam int LINE_BYTES_DEF = 512;
    localparam int QUEUE_DEPTH    = 2;
    localparam int PADDR_W        = 3;

    localparam logic [7:0] CH_CR            = 8'd13;
    localparam logic [7:0] CH_LF            = 8'd10;
    localparam logic [7:0] LINE_COUNT_RESET = 8'd10;

    // input opcodes
    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_EOS   = 2'd1;
    localparam logic [1:0] OP_FETCH = 2'd2;

    // register index, decoded from paddr[2]
    localparam logic REG_LINE_COUNT = 1'b0;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_value;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       last_byte;
    } result_t;

    typedef enum logic [1:0] {
        CMD_CHAR,
        CMD_LF,
        CMD_EOS,
        CMD_FETCH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_REDUCE,
        BK_READ
    } back_state_t;

endpackage
`default_nettype wire

[src/llrb_front.sv]
// front end: accepts items, drops carriage returns and unused opcodes, classifies the rest
`timescale 1ns / 1ps
`default_nettype none
module llrb_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire llrb_pkg::item_t item,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output llrb_pkg::cmd_t       push_cmd
);
    import llrb_pkg::*;

    logic front_valid_reg;
    logic front_valid_next;
    cmd_t front_cmd_reg;
    cmd_t front_cmd_next;
    cmd_t cls_cmd;
    logic cls_keep;
    logic accept;
    logic push;

    always_comb
    begin
        cls_cmd.data = item.byte_value;
        cls_cmd.kind = CMD_CHAR;
        cls_keep     = 1'b0;
        unique case (item.opcode)
            OP_DATA:
            begin
                cls_keep     = (item.byte_value != CH_CR);
                cls_cmd.kind = (item.byte_value == CH_LF) ? CMD_LF : CMD_CHAR;
            end
            OP_EOS:
            begin
                cls_keep     = 1'b1;
                cls_cmd.kind = CMD_EOS;
            end
            OP_FETCH:
            begin
                cls_keep     = 1'b1;
                cls_cmd.kind = CMD_FETCH;
            end
            default:
            begin
                cls_keep = 1'b0;
            end
        endcase
    end

    assign push   = front_valid_reg && push_ready;
    assign busy   = front_valid_reg && !push_ready;
    assign accept = start && !busy;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        front_cmd_next   = front_cmd_reg;
        if (accept && cls_keep)
        begin
            front_valid_next = 1'b1;
            front_cmd_next   = cls_cmd;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_cmd_reg <= front_cmd_next;
    end

    assign push_valid = front_valid_reg;
    assign push_cmd   = front_cmd_reg;

endmodule
`default_nettype wire

[src/llrb_queue.sv]
// short command queue between the front end and the line store engine
`timescale 1ns / 1ps
`default_nettype none
module llrb_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire llrb_pkg::cmd_t in_cmd,
    output logic                out_valid,
    input  wire logic           out_pop,
    output llrb_pkg::cmd_t      out_cmd
);
    import llrb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule
`default_nettype wire

[src/llrb_back.sv]
// line store engine: ring of line slots, length table and readout sequencer
`timescale 1ns / 1ps
`default_nettype none
module llrb_back #(
    parameter int MAX_LINES  = llrb_pkg::MAX_LINES_DEF,
    parameter int LINE_BYTES = llrb_pkg::LINE_BYTES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [7:0]     line_count,
    input  wire logic           cmd_valid,
    output logic                cmd_pop,
    input  wire llrb_pkg::cmd_t cmd,
    output logic                strobe,
    output llrb_pkg::result_t   result
);
    import llrb_pkg::*;

    localparam int SLOT_W      = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CNT_W       = $clog2(MAX_LINES + 1);
    localparam int POS_W       = $clog2(LINE_BYTES);
    localparam int ADDR_W      = SLOT_W + POS_W;
    localparam int STORE_DEPTH = MAX_LINES * (1 << POS_W);

    logic [7:0]       store_mem [STORE_DEPTH];
    logic [POS_W-1:0] len_mem   [MAX_LINES];

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [SLOT_W-1:0] write_slot_reg;
    logic [SLOT_W-1:0] write_slot_next;
    logic [CNT_W-1:0]  lines_held_reg;
    logic [CNT_W-1:0]  lines_held_next;
    logic [POS_W-1:0]  char_pos_reg;
    logic [POS_W-1:0]  char_pos_next;
    logic              readout_reg;
    logic              readout_next;
    logic [CNT_W-1:0]  rd_line_reg;
    logic [CNT_W-1:0]  rd_line_next;
    logic [POS_W-1:0]  rd_char_reg;
    logic [POS_W-1:0]  rd_char_next;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic [SLOT_W-1:0] rd_idx_next;
    logic [SLOT_W-1:0] work_reg;
    logic [SLOT_W-1:0] work_next;
    logic              res_strobe_reg;
    logic              res_strobe_next;
    result_t           res_reg;
    result_t           res_next;
    logic [7:0]        store_rd_reg;
    logic [POS_W-1:0]  len_rd_reg;

    logic [CNT_W-1:0]  ring_n;
    logic [CNT_W-1:0]  held_eff;
    logic [SLOT_W-1:0] close_ws;
    logic [CNT_W-1:0]  close_held;
    logic [SLOT_W-1:0] eos_ws;
    logic [CNT_W-1:0]  eos_held_c;
    logic [CNT_W-1:0]  eos_held;
    logic              eos_start;
    logic [CNT_W:0]    base_sum;
    logic [CNT_W:0]    base_idx;
    logic              store_we;
    logic              len_we;
    logic              rd_en;

    // ring size and the values a line close would leave
    always_comb
    begin
        if (line_count == 8'd0 || 32'(line_count) > MAX_LINES)
        begin
            ring_n = CNT_W'(MAX_LINES);
        end
        else
        begin
            ring_n = CNT_W'(line_count);
        end
        held_eff   = (lines_held_reg > ring_n) ? ring_n : lines_held_reg;
        close_ws   = (32'(write_slot_reg) + 1 >= 32'(ring_n)) ? '0 : write_slot_reg + 1'b1;
        close_held = (lines_held_reg < ring_n) ? lines_held_reg + 1'b1 : ring_n;
        eos_ws     = (char_pos_reg != '0) ? close_ws : write_slot_reg;
        eos_held_c = (char_pos_reg != '0) ? close_held : lines_held_reg;
        eos_held   = (eos_held_c > ring_n) ? ring_n : eos_held_c;
        eos_start  = !readout_reg && (eos_held != '0);
        // oldest line: reduced write slot plus n minus held, wrapped once
        base_sum   = (CNT_W+1)'(work_reg) + (CNT_W+1)'(ring_n) - (CNT_W+1)'(held_eff);
        base_idx   = (base_sum >= (CNT_W+1)'(ring_n)) ? base_sum - (CNT_W+1)'(ring_n)
                                                      : base_sum;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && cmd.kind == CMD_EOS && eos_start)
                begin
                    state_next = BK_REDUCE;
                end
                else if (cmd_valid && cmd.kind == CMD_FETCH && readout_reg)
                begin
                    state_next = BK_READ;
                end
            end
            BK_REDUCE:
            begin
                if ((CNT_W+1)'(work_reg) < (CNT_W+1)'(ring_n))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_READ:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        write_slot_next = write_slot_reg;
        lines_held_next = lines_held_reg;
        char_pos_next   = char_pos_reg;
        readout_next    = readout_reg;
        rd_line_next    = rd_line_reg;
        rd_char_next    = rd_char_reg;
        rd_idx_next     = rd_idx_reg;
        work_next       = work_reg;
        res_strobe_next = 1'b0;
        res_next        = '0;
        cmd_pop         = 1'b0;
        store_we        = 1'b0;
        len_we          = 1'b0;
        rd_en           = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        CMD_CHAR:
                        begin
                            if (!readout_reg && 32'(char_pos_reg) < LINE_BYTES - 1)
                            begin
                                store_we      = 1'b1;
                                char_pos_next = char_pos_reg + 1'b1;
                            end
                        end
                        CMD_LF:
                        begin
                            if (!readout_reg)
                            begin
                                len_we          = 1'b1;
                                write_slot_next = close_ws;
                                lines_held_next = close_held;
                                char_pos_next   = '0;
                            end
                        end
                        CMD_EOS:
                        begin
                            if (!readout_reg)
                            begin
                                len_we          = (char_pos_reg != '0);
                                write_slot_next = eos_ws;
                                lines_held_next = eos_held;
                                char_pos_next   = '0;
                                if (eos_start)
                                begin
                                    readout_next = 1'b1;
                                    rd_line_next = '0;
                                    rd_char_next = '0;
                                    work_next    = eos_ws;
                                end
                            end
                        end
                        CMD_FETCH:
                        begin
                            if (readout_reg)
                            begin
                                rd_en = 1'b1;
                            end
                            else
                            begin
                                res_strobe_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_REDUCE:
            begin
                // write slot can sit above a shrunken ring: subtract n until it fits
                if ((CNT_W+1)'(work_reg) >= (CNT_W+1)'(ring_n))
                begin
                    work_next = SLOT_W'((CNT_W+1)'(work_reg) - (CNT_W+1)'(ring_n));
                end
                else
                begin
                    rd_idx_next = SLOT_W'(base_idx);
                end
            end
            BK_READ:
            begin
                res_strobe_next    = 1'b1;
                res_next.out_valid = 1'b1;
                if (rd_char_reg < len_rd_reg)
                begin
                    res_next.out_byte = store_rd_reg;
                    rd_char_next      = rd_char_reg + 1'b1;
                end
                else
                begin
                    res_next.out_byte = CH_LF;
                    rd_char_next      = '0;
                    rd_line_next      = rd_line_reg + 1'b1;
                    rd_idx_next       = (32'(rd_idx_reg) + 1 >= 32'(ring_n)) ? '0
                                                                           : rd_idx_reg + 1'b1;
                    if (32'(rd_line_reg) + 1 >= 32'(held_eff))
                    begin
                        res_next.last_byte = 1'b1;
                        write_slot_next    = '0;
                        lines_held_next    = '0;
                        char_pos_next      = '0;
                        readout_next       = 1'b0;
                        rd_line_next       = '0;
                        rd_idx_next        = '0;
                    end
                end
            end
            default:
            begin
                res_strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            write_slot_reg <= '0;
            lines_held_reg <= '0;
            char_pos_reg   <= '0;
            readout_reg    <= 1'b0;
            rd_line_reg    <= '0;
            rd_char_reg    <= '0;
            rd_idx_reg     <= '0;
            work_reg       <= '0;
            res_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            lines_held_reg <= lines_held_next;
            char_pos_reg   <= char_pos_next;
            readout_reg    <= readout_next;
            rd_line_reg    <= rd_line_next;
            rd_char_reg    <= rd_char_next;
            rd_idx_reg     <= rd_idx_next;
            work_reg       <= work_next;
            res_strobe_reg <= res_strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // line bytes, addressed by slot and position
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[ADDR_W'({write_slot_reg, char_pos_reg})] <= cmd.data;
        end
        if (rd_en)
        begin
            store_rd_reg <= store_mem[ADDR_W'({rd_idx_reg, rd_char_reg})];
        end
    end

    // line lengths, one per slot
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[write_slot_reg] <= char_pos_reg;
        end
        if (rd_en)
        begin
            len_rd_reg <= len_mem[rd_idx_reg];
        end
    end

    assign strobe = res_strobe_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

[src/last_n_lines_ring_buffer.sv]
// Top level of the last-n-lines ring buffer.
// A fetch result passes the front-end register, the queue and the engine's result register;
// during a readout it also passes the store read and the read state. Results can't stall.
// Throughput: data bytes, newlines and empty fetches one per cycle while the engine is idle;
// a fetch during readout also passes the read state; an end of stream that starts a readout
// first reduces the write slot below the ring size. Reset clears control state, line_count to 10.
`timescale 1ns / 1ps
`default_nettype none
module last_n_lines_ring_buffer #(
    parameter int MAX_LINES  = llrb_pkg::MAX_LINES_DEF,
    parameter int LINE_BYTES = llrb_pkg::LINE_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire llrb_pkg::item_t              item,
    output logic                              strobe,
    output llrb_pkg::result_t                 result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [llrb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import llrb_pkg::*;

    logic [7:0] line_count_reg;
    logic [7:0] line_count_next;
    logic       push_valid;
    logic       push_ready;
    cmd_t       push_cmd;
    logic       q_valid;
    logic       q_pop;
    cmd_t       q_cmd;
    logic       reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_LINE_COUNT);
    assign prdata  = reg_hit ? {24'd0, line_count_reg} : 32'd0;

    always_comb
    begin
        line_count_next = line_count_reg;
        if (psel && penable && pwrite && pready && reg_hit)
        begin
            line_count_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= LINE_COUNT_RESET;
        end
        else
        begin
            line_count_reg <= line_count_next;
        end
    end

    llrb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    llrb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_cmd    (push_cmd),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_cmd   (q_cmd)
    );

    llrb_back #(
        .MAX_LINES  (MAX_LINES),
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_count (line_count_reg),
        .cmd_valid  (q_valid),
        .cmd_pop    (q_pop),
        .cmd        (q_cmd),
        .strobe     (strobe),
        .result     (result)
    );

endmodule
`default_nettype wire

[src/llrb_checker.sv]
// port-level checks for the last-n-lines ring buffer and their binding
`timescale 1ns / 1ps
`default_nettype none
module llrb_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         strobe,
    input wire llrb_pkg::result_t            result,
    input wire logic [llrb_pkg::PADDR_W-1:0] paddr,
    input wire logic [31:0]                  prdata,
    input wire logic                         pready
);
    import llrb_pkg::*;

    // an empty fetch carries no byte and no end mark
    a_empty_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.out_valid) |-> (result.out_byte == 8'd0 && !result.last_byte))
        else $error("empty fetch result carries data");

    // end of readout is always a valid newline
    a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last_byte) |-> (result.out_valid && result.out_byte == CH_LF))
        else $error("last byte is not a valid newline");

    // no transaction leaves right after reset is released
    a_quiet_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !strobe)
        else $error("result strobe right after reset");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // line_count is 8 bits and the unused address reads zero
    a_prdata_range: assert property (@(posedge clk) disable iff (!rst_n)
        (prdata[31:8] == 24'd0) && (paddr[2] == REG_LINE_COUNT || prdata == 32'd0))
        else $error("read data out of range");

endmodule

bind last_n_lines_ring_buffer llrb_checker u_llrb_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .strobe (strobe),
    .result (result),
    .paddr  (paddr),
    .prdata (prdata),
    .pready (pready)
);
`default_nettype wire
